// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked on every clock edge outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked on every clock edge, reset included
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/fbsc_pkg.sv -----
// package with constants and pipeline types of the frustum box sphere cull
package fbsc_pkg;

    localparam int PLANE_COUNT    = 6;
    localparam int NUM_PLANES     = 6;
    localparam int SQRT_STAGES    = 31;
    localparam logic [15:0] MAP_SCALE_RESET = 16'd256;

    typedef enum logic [2:0] {
        REG_PLANE_RIGHT  = 3'd0,
        REG_PLANE_LEFT   = 3'd1,
        REG_PLANE_TOP    = 3'd2,
        REG_PLANE_BOTTOM = 3'd3,
        REG_PLANE_NEAR   = 3'd4,
        REG_PLANE_FAR    = 3'd5,
        REG_MAP_SCALE    = 3'd6,
        REG_SPARE        = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [16:0] sx;
        logic signed [16:0] sy;
        logic signed [16:0] sz;
        logic        [33:0] d2;
        logic        [34:0] rem;
        logic        [30:0] root;
    } sqrt_stage_t;

    typedef struct packed {
        logic signed [16:0] sx;
        logic signed [16:0] sy;
        logic signed [16:0] sz;
        logic        [30:0] root;
    } center_t;

endpackage

// ----- src/frustum_box_sphere_cull.sv -----
// top level of the frustum box sphere cull pipeline
// Takes one box per cycle and returns one visibility bit per box, in order.
// From request to result, the first stages form the center, the extents and
// the squared diagonal, the next run the one-bit-per-stage square root of the
// diagonal, the next do the per-plane multiply, sum, scale and compare, and a
// last stage combines the planes into the result register. The whole pipeline
// holds while a result waits on m_ready.
// Plane and scale registers must be written only while the pipeline is empty.
module frustum_box_sphere_cull (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_min_x,
    input  logic signed [15:0] s_min_y,
    input  logic signed [15:0] s_min_z,
    input  logic signed [15:0] s_max_x,
    input  logic signed [15:0] s_max_y,
    input  logic signed [15:0] s_max_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_visible,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [63:0] cfg_data
);

    localparam int NS = fbsc_pkg::SQRT_STAGES;
    localparam int NP = fbsc_pkg::NUM_PLANES;

    logic [NP-1:0][63:0] plane_reg;
    logic [15:0]         scale_reg;
    logic                en;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
            scale_reg <= fbsc_pkg::MAP_SCALE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == fbsc_pkg::REG_MAP_SCALE) begin
                scale_reg <= cfg_data[15:0];
            end else if (cfg_index < fbsc_pkg::REG_MAP_SCALE) begin
                plane_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // front stages: sums and differences, squares, squared diagonal
    logic signed [16:0] sx0_reg, sy0_reg, sz0_reg, dx0_reg, dy0_reg, dz0_reg;
    logic signed [16:0] sx1_reg, sy1_reg, sz1_reg;
    logic        [31:0] qx1_reg, qy1_reg, qz1_reg;
    logic        [1:0]  fv_reg;

    fbsc_pkg::sqrt_stage_t sq_reg [0:NS];
    logic [NS:0]           sv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg    <= '0;
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            fv_reg    <= {fv_reg[0], s_valid};
            sv_reg[0] <= fv_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx0_reg <= 17'(s_min_x) + 17'(s_max_x);
            sy0_reg <= 17'(s_min_y) + 17'(s_max_y);
            sz0_reg <= 17'(s_min_z) + 17'(s_max_z);
            dx0_reg <= 17'(s_max_x) - 17'(s_min_x);
            dy0_reg <= 17'(s_max_y) - 17'(s_min_y);
            dz0_reg <= 17'(s_max_z) - 17'(s_min_z);
            sx1_reg <= sx0_reg;
            sy1_reg <= sy0_reg;
            sz1_reg <= sz0_reg;
            qx1_reg <= 32'(34'(dx0_reg * dx0_reg));
            qy1_reg <= 32'(34'(dy0_reg * dy0_reg));
            qz1_reg <= 32'(34'(dz0_reg * dz0_reg));
            sq_reg[0].sx   <= sx1_reg;
            sq_reg[0].sy   <= sy1_reg;
            sq_reg[0].sz   <= sz1_reg;
            sq_reg[0].d2   <= 34'(qx1_reg) + 34'(qy1_reg) + 34'(qz1_reg);
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        logic [61:0] rad;
        logic [34:0] trial_rem;
        logic [34:0] trial_sub;
        fbsc_pkg::sqrt_stage_t nxt;

        always_comb begin
            rad       = {sq_reg[k].d2, 28'd0};
            trial_rem = {sq_reg[k].rem[32:0], rad[61-2*k -: 2]};
            trial_sub = {2'b00, sq_reg[k].root, 2'b01};
            nxt       = sq_reg[k];
            if (trial_rem >= trial_sub) begin
                nxt.rem  = trial_rem - trial_sub;
                nxt.root = {sq_reg[k].root[29:0], 1'b1};
            end else begin
                nxt.rem  = trial_rem;
                nxt.root = {sq_reg[k].root[29:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k+1] <= 1'b0;
            end else if (en) begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[k+1] <= nxt;
            end
        end
    end

    // plane test stages
    fbsc_pkg::center_t   c0;
    fbsc_pkg::center_t   c1_reg;
    logic                pass_v_reg [0:3];
    logic signed [32:0]  pa_reg [NP];
    logic signed [32:0]  pb_reg [NP];
    logic signed [32:0]  pc_reg [NP];
    logic signed [35:0]  t_reg  [NP];
    logic signed [52:0]  m_reg  [NP];
    logic [NP-1:0]       pass_reg;
    logic                vis_reg;

    assign c0.sx   = sq_reg[NS].sx;
    assign c0.sy   = sq_reg[NS].sy;
    assign c0.sz   = sq_reg[NS].sz;
    assign c0.root = sq_reg[NS].root;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_v_reg[0] <= 1'b0;
            pass_v_reg[1] <= 1'b0;
            pass_v_reg[2] <= 1'b0;
            pass_v_reg[3] <= 1'b0;
            vis_reg       <= 1'b0;
        end else if (en) begin
            pass_v_reg[0] <= sv_reg[NS];
            pass_v_reg[1] <= pass_v_reg[0];
            pass_v_reg[2] <= pass_v_reg[1];
            pass_v_reg[3] <= pass_v_reg[2];
            vis_reg       <= pass_v_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg <= c0;
        end
    end

    for (genvar p = 0; p < NP; p++) begin : g_plane
        logic signed [15:0] pa_c, pb_c, pc_c, pd_c;
        logic signed [53:0] sum;
        assign pa_c = plane_reg[p][15:0];
        assign pb_c = plane_reg[p][31:16];
        assign pc_c = plane_reg[p][47:32];
        assign pd_c = plane_reg[p][63:48];
        assign sum  = 54'(m_reg[p]) + (54'(pd_c) <<< 19);

        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[p]   <= pa_c * c0.sy;
                pb_reg[p]   <= pb_c * c0.sz;
                pc_reg[p]   <= pc_c * c0.sx;
                t_reg[p]    <= 36'(pa_reg[p]) + 36'(pb_reg[p]) - 36'(pc_reg[p])
                               + $signed({5'd0, c1_reg.root});
                m_reg[p]    <= t_reg[p] * $signed({1'b0, scale_reg});
                pass_reg[p] <= (p >= fbsc_pkg::PLANE_COUNT) || (sum > 54'sd0);
            end
        end
    end

    logic m_visible_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_visible_reg <= &pass_reg;
        end
    end

    assign m_valid   = vis_reg;
    assign m_visible = m_visible_reg;

endmodule

// ----- src/fbsc_checker.sv -----
// port-level checker for the frustum box sphere cull, bound to the top level
`include "assert_macros.svh"

module fbsc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_visible,
    input logic cfg_ready
);

    `ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `ASSERT_IMPL(a_ready_follows_sink, aclk, aresetn, m_valid, s_ready == m_ready)
    `ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_visible))
    `ASSERT_ALWAYS_NEXT(a_reset_empties, aclk, !aresetn, !m_valid && cfg_ready)

endmodule

bind frustum_box_sphere_cull fbsc_checker u_fbsc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_visible (m_visible),
    .cfg_ready (cfg_ready)
);

// ----- test/frustum_box_sphere_cull_test.sv -----
// testbench for the frustum box sphere cull: random and directed boxes checked against a predictor
`timescale 1ns / 1ps

module frustum_box_sphere_cull_test;

    localparam int PIPE_LATENCY = 39;

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] min_z;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
        logic signed [15:0] max_z;
    } box_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_min_x, s_min_y, s_min_z, s_max_x, s_max_y, s_max_z;
    logic               m_valid;
    logic               m_ready;
    logic               m_visible;
    logic               cfg_valid;
    logic               cfg_ready;
    logic        [2:0]  cfg_index;
    logic        [63:0] cfg_data;

    logic [63:0] plane_shadow [fbsc_pkg::NUM_PLANES];
    logic [15:0] scale_shadow;

    bit   expected_visible_q [$];
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_end;
    int   cycle_count;
    int   mismatches;
    int   boxes_sent;
    int   visible_seen;
    int   culled_seen;
    int   cfg_writes;

    frustum_box_sphere_cull uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_min_x   (s_min_x),
        .s_min_y   (s_min_y),
        .s_min_z   (s_min_z),
        .s_max_x   (s_max_x),
        .s_max_y   (s_max_y),
        .s_max_z   (s_max_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_visible (m_visible),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit predict_visible(box_t b);
        longint sx, sy, sz, dx, dy, dz, s, rad, total;
        longint pa, pb, pc, pd;
        longint unsigned rem, root, bitv;
        logic [63:0] w;
        bit vis;
        sx = longint'(b.min_x) + longint'(b.max_x);
        sy = longint'(b.min_y) + longint'(b.max_y);
        sz = longint'(b.min_z) + longint'(b.max_z);
        dx = longint'(b.max_x) - longint'(b.min_x);
        dy = longint'(b.max_y) - longint'(b.min_y);
        dz = longint'(b.max_z) - longint'(b.min_z);
        s = longint'({48'd0, scale_shadow});
        // diagonal with 14 fraction bits, truncated
        rem = longint'(dx * dx + dy * dy + dz * dz) << 28;
        root = 0;
        bitv = 64'h1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        rad = longint'(root) * s;
        vis = 1'b1;
        for (int p = 0; p < fbsc_pkg::PLANE_COUNT && p < fbsc_pkg::NUM_PLANES; p++) begin
            w = plane_shadow[p];
            pa = longint'($signed(w[15:0]));
            pb = longint'($signed(w[31:16]));
            pc = longint'($signed(w[47:32]));
            pd = longint'($signed(w[63:48]));
            total = pa * sy * s + pb * sz * s - pc * sx * s + pd * 524288 + rad;
            if (total <= 0) vis = 1'b0;
        end
        return vis;
    endfunction

    function automatic logic [63:0] pack_plane(logic [15:0] a, logic [15:0] b,
                                               logic [15:0] c, logic [15:0] d);
        return {d, c, b, a};
    endfunction

    // half open planes, half fully random coefficients
    function automatic logic [63:0] random_plane();
        if ($urandom_range(1) == 0) begin
            return pack_plane(16'($signed($urandom_range(4000)) - 2000),
                              16'($signed($urandom_range(4000)) - 2000),
                              16'($signed($urandom_range(4000)) - 2000),
                              16'($urandom_range(32767, 20000)));
        end
        return pack_plane(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    function automatic box_t random_box();
        box_t b;
        b.min_x = 16'($urandom);
        b.min_y = 16'($urandom);
        b.min_z = 16'($urandom);
        if ($urandom_range(2) == 0) begin
            b.max_x = 16'($urandom);
            b.max_y = 16'($urandom);
            b.max_z = 16'($urandom);
        end else begin
            b.max_x = b.min_x + 16'($urandom_range(600));
            b.max_y = b.min_y + 16'($urandom_range(600));
            b.max_z = b.min_z + 16'($urandom_range(600));
        end
        return b;
    endfunction

    function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
        box_t b;
        b.min_x = 16'(x0);
        b.min_y = 16'(y0);
        b.min_z = 16'(z0);
        b.max_x = 16'(x1);
        b.max_y = 16'(y1);
        b.max_z = 16'(z1);
        return b;
    endfunction

    // receiver stall generator with its own cycle count
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            m_ready <= (cycle_count >= hold_end) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_visible_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result visible=%0b", m_visible);
            end else begin
                bit want;
                want = expected_visible_q.pop_front();
                if (m_visible) visible_seen++;
                else culled_seen++;
                if (m_visible !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("visible mismatch: expected %0b actual %0b", want, m_visible);
                end
            end
        end
    end

    task automatic send_box(box_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_min_x <= b.min_x;
        s_min_y <= b.min_y;
        s_min_z <= b.min_z;
        s_max_x <= b.max_x;
        s_max_y <= b.max_y;
        s_max_z <= b.max_z;
        do @(posedge aclk); while (!s_ready);
        expected_visible_q.push_back(predict_visible(b));
        boxes_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_visible_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(fbsc_pkg::reg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx < fbsc_pkg::REG_MAP_SCALE) plane_shadow[idx] = value;
        else if (idx == fbsc_pkg::REG_MAP_SCALE) scale_shadow = value[15:0];
        @(posedge aclk);
    endtask

    task automatic write_all_planes(bit random_fill, logic [63:0] value);
        for (int p = 0; p < fbsc_pkg::NUM_PLANES; p++)
            write_reg(fbsc_pkg::reg_index_t'(p), random_fill ? random_plane() : value);
    endtask

    // zero planes after reset: only boxes of zero size are culled
    task automatic test_reset_defaults();
        send_box(make_box(5, 5, 5, 5, 5, 5));
        send_box(make_box(0, 0, 0, 1, 0, 0));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(100, 100, 100, -100, -100, -100));
        wait_drained();
    endtask

    task automatic test_directed_extremes();
        write_all_planes(1'b0, pack_plane(16'h4000, 16'h0000, 16'h0000, 16'h0000));
        write_reg(fbsc_pkg::REG_MAP_SCALE, 64'd256);
        send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(make_box(-32768, 0, 0, 32767, 0, 0));
        send_box(make_box(32767, -32768, 32767, -32768, 32767, -32768));
        send_box(make_box(0, -10, 0, 0, 10, 0));
        send_box(make_box(0, -10, 0, 0, 9, 0));
        wait_drained();
        // full scale and all-ones coefficients
        write_reg(fbsc_pkg::REG_MAP_SCALE, 64'd65535);
        write_all_planes(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(1, 2, 3, 1, 2, 3));
        send_box(make_box(-5, -5, -5, 5, 5, 5));
        wait_drained();
        // zero scale leaves only d to decide
        write_reg(fbsc_pkg::REG_MAP_SCALE, 64'd0);
        write_all_planes(1'b0, pack_plane(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001));
        send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(make_box(300, 300, 300, -300, -300, -300));
        wait_drained();
        write_reg(fbsc_pkg::REG_PLANE_FAR,
                  pack_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_box(make_box(3, 4, 5, 6, 7, 8));
        wait_drained();
        // spare index must not disturb the scale or any plane
        write_reg(fbsc_pkg::REG_SPARE, 64'h0000_0000_0000_0000);
        send_box(make_box(-1, -1, -1, 1, 1, 1));
        wait_drained();
    endtask

    task automatic test_random_phases();
        int idle_set  [4] = '{0, 52, 0, 35};
        int stall_set [4] = '{0, 0, 52, 35};
        logic [15:0] scale_set [4] = '{16'd256, 16'd65535, 16'($urandom), 16'd0};
        for (int ph = 0; ph < 4; ph++) begin
            write_all_planes(1'b1, 64'd0);
            write_reg(fbsc_pkg::REG_MAP_SCALE, {48'd0, scale_set[ph]});
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            for (int i = 0; i < 300; i++) send_box(random_box());
            wait_drained();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // long receiver hold fills the pipeline while requests keep coming
    task automatic test_backpressure();
        write_all_planes(1'b1, 64'd0);
        write_reg(fbsc_pkg::REG_MAP_SCALE, 64'($urandom_range(65535)));
        hold_end = cycle_count + 400;
        for (int i = 0; i < 233; i++) send_box(random_box());
        wait_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_min_x        = '0;
        s_min_y        = '0;
        s_min_z        = '0;
        s_max_x        = '0;
        s_max_y        = '0;
        s_max_z        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = fbsc_pkg::REG_PLANE_RIGHT;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_end       = 0;
        mismatches     = 0;
        boxes_sent     = 0;
        visible_seen   = 0;
        culled_seen    = 0;
        cfg_writes     = 0;
        for (int p = 0; p < fbsc_pkg::NUM_PLANES; p++) plane_shadow[p] = '0;
        scale_shadow = fbsc_pkg::MAP_SCALE_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed_extremes();
        test_random_phases();
        test_backpressure();

        repeat (PIPE_LATENCY + 10) @(posedge aclk);
        mismatches += expected_visible_q.size();
        $display("boxes sent %0d, visible %0d, culled %0d, register writes %0d",
                 boxes_sent, visible_seen, culled_seen, cfg_writes);
        $display("scales covered zero, unity, full and random under four idle mixes");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
